// ===== hw/rtl/lcst_pkg.sv =====
// Shared widths, types and helpers for the load-cell tare and hex frame block.
// Used by every module under hw/rtl; depends on nothing.
package lcst_pkg;

	localparam int CODE_W       = 24;  // width of one converter code on the bus
	localparam int SAMPLE_BITS  = 24;  // bits of each code that are used
	localparam int TARE_SAMPLES = 15;  // sums averaged into the tare

	localparam int SUM_W   = SAMPLE_BITS + 2;                  // sum of four codes
	localparam int CNT_W   = $clog2(TARE_SAMPLES + 1);         // tare sample counter
	localparam int TOT_W   = SUM_W + $clog2(TARE_SAMPLES + 1); // tare running total

	// floor(total / TARE_SAMPLES) as (total * DIV_RECIP) >> DIV_SH, exact for any TOT_W total
	localparam int          DIV_SH    = TOT_W + $clog2(TARE_SAMPLES);
	localparam int          RECIP_W   = TOT_W + 1;
	localparam int          PROD_W    = TOT_W + RECIP_W;
	localparam logic [63:0] DIV_RECIP = ((64'd1 << DIV_SH) + 64'(TARE_SAMPLES - 1))
		/ 64'(TARE_SAMPLES);

	localparam int MAG_W     = 32;  // magnitude shown in the frame
	localparam int FRAME_LEN = 13;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_ONE    = 8'h31;
	localparam logic [7:0] ASCII_X      = 8'h78;
	localparam logic [7:0] ASCII_HEX_AF = 8'h37;  // 'A' - 10

	typedef struct packed {
		logic             retare;
		logic [SUM_W-1:0] sum;
	} item_t;

	typedef struct packed {
		logic             neg;
		logic [SUM_W-1:0] mag;
	} wgt_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = ASCII_ZERO + {4'd0, nib};
		end else begin
			ch = ASCII_HEX_AF + {4'd0, nib};
		end
		return ch;
	endfunction

endpackage

// ===== hw/rtl/lcst_input.sv =====
// Input stage: takes a beat, flips the code sign bits and registers the sum.
// Depends on lcst_pkg.
module lcst_input (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [4*lcst_pkg::CODE_W-1:0] s_tdata,   // code_a, code_b, code_c, code_d
	input  logic                         s_tuser,   // retare
	input  logic                         take,
	output logic                         valid,
	output lcst_pkg::item_t              item
);
	import lcst_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic [SUM_W-1:0] off [4];
	logic [SUM_W-1:0] sum;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			// two's complement to offset binary
			off[i] = SUM_W'({~s_tdata[i*CODE_W + SAMPLE_BITS - 1],
				s_tdata[i*CODE_W +: SAMPLE_BITS-1]});
		end
		sum = (off[0] + off[1]) + (off[2] + off[3]);
	end

	assign s_tready = !valid_s1 || take;
	assign valid    = valid_s1;
	assign item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.retare <= s_tuser;
			item_s1.sum    <= sum;
		end
	end

endmodule

// ===== hw/rtl/lcst_tare.sv =====
// Tare accumulation, reciprocal-multiply divide by the sample count, weight = sum - tare.
// Depends on lcst_pkg.
module lcst_tare (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  lcst_pkg::item_t item,
	input  logic            frame_free,
	output logic            take,
	output logic            wgt_load,
	output lcst_pkg::wgt_t  wgt
);
	import lcst_pkg::*;

	logic [CNT_W-1:0]   tare_count_q;
	logic [TOT_W-1:0]   tare_total_q;
	logic [SUM_W-1:0]   tare_value_q;

	logic               div_busy_q;

	logic [CNT_W-1:0]   eff_count;
	logic [CNT_W-1:0]   count_next;
	logic [TOT_W-1:0]   eff_total;
	logic [TOT_W-1:0]   total_next;
	logic               tare_phase;

	logic [PROD_W-1:0]  quot_prod;

	always_comb begin
		eff_count  = item.retare ? '0 : tare_count_q;
		eff_total  = item.retare ? '0 : tare_total_q;
		tare_phase = eff_count < CNT_W'(TARE_SAMPLES);
		count_next = eff_count + 1'b1;
		total_next = eff_total + TOT_W'(item.sum);

		take     = valid && !div_busy_q && (tare_phase || frame_free);
		wgt_load = take && !tare_phase;

		wgt.neg = item.sum < tare_value_q;
		wgt.mag = wgt.neg ? (tare_value_q - item.sum) : (item.sum - tare_value_q);

		// quotient taken from the registered total, in the cycle after the last tare beat
		quot_prod = PROD_W'(tare_total_q) * PROD_W'(DIV_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_count_q <= '0;
			tare_total_q <= '0;
			tare_value_q <= '0;
			div_busy_q   <= 1'b0;
		end else if (div_busy_q) begin
			div_busy_q   <= 1'b0;
			tare_value_q <= quot_prod[DIV_SH +: SUM_W];
		end else if (take && tare_phase) begin
			tare_count_q <= count_next;
			tare_total_q <= total_next;
			if (count_next == CNT_W'(TARE_SAMPLES)) begin
				div_busy_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/lcst_frame.sv =====
// Frame register and character serializer: one ASCII character per beat.
// Depends on lcst_pkg.
module lcst_frame (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wgt_load,
	input  lcst_pkg::wgt_t wgt,
	output logic           frame_free,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,   // out_char
	output logic           m_tlast    // frame_last
);
	import lcst_pkg::*;

	localparam logic [IDX_W-1:0] CH_SIGN   = IDX_W'(0);
	localparam logic [IDX_W-1:0] CH_ZERO   = IDX_W'(1);
	localparam logic [IDX_W-1:0] CH_X      = IDX_W'(2);
	localparam logic [IDX_W-1:0] CH_DIG_LO = IDX_W'(10);  // least significant digit
	localparam logic [IDX_W-1:0] CH_CHK_HI = IDX_W'(11);
	localparam logic [IDX_W-1:0] CH_CHK_LO = IDX_W'(12);

	logic             frame_valid_q;
	logic [IDX_W-1:0] char_index_q;
	logic             neg_q;
	logic [MAG_W-1:0] mag_q;
	logic [7:0]       chk_q;

	logic             last_beat;
	logic [IDX_W-1:0] dig_pos;
	logic [3:0]       nib;
	logic [MAG_W-1:0] mag_ext;

	assign mag_ext    = MAG_W'(wgt.mag);
	assign last_beat  = char_index_q == CH_CHK_LO;
	assign frame_free = !frame_valid_q || (m_tready && last_beat);
	assign m_tvalid   = frame_valid_q;
	assign m_tlast    = last_beat;

	always_comb begin
		dig_pos = CH_DIG_LO - char_index_q;
		nib     = mag_q[{dig_pos[2:0], 2'b00} +: 4];
		unique case (char_index_q)
			CH_SIGN:   m_tdata = neg_q ? ASCII_ONE : ASCII_ZERO;
			CH_ZERO:   m_tdata = ASCII_ZERO;
			CH_X:      m_tdata = ASCII_X;
			CH_CHK_HI: m_tdata = hex_char(chk_q[7:4]);
			CH_CHK_LO: m_tdata = hex_char(chk_q[3:0]);
			default:   m_tdata = hex_char(nib);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
			char_index_q  <= '0;
		end else if (wgt_load) begin
			frame_valid_q <= 1'b1;
			char_index_q  <= CH_SIGN;
		end else if (frame_valid_q && m_tready) begin
			if (last_beat) begin
				frame_valid_q <= 1'b0;
				char_index_q  <= CH_SIGN;
			end else begin
				char_index_q <= char_index_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wgt_load) begin
			neg_q <= wgt.neg;
			mag_q <= mag_ext;
			chk_q <= mag_ext[7:0] ^ mag_ext[15:8] ^ mag_ext[23:16] ^ mag_ext[31:24];
		end
	end

endmodule

// ===== hw/rtl/load_cell_sum_tare_hex_frame.sv =====
// Load-cell summer with tare: each input beat carries four 24-bit two's-complement
// converter codes; their offset-binary sum is averaged into a tare over the first 15
// beats after reset or from a beat with retare set on, and every later beat sends a
// 13-character ASCII frame (sign, "0x", 8 hex digits of |sum - tare|, 2 hex digits of
// the byte-XOR check), last character flagged by m_tlast. Rate: a tare beat is
// taken without waiting on the output; a weight beat occupies the output for 13
// beats, one character per cycle while m_tready is high, and the next beat is
// accepted and held meanwhile. When the 15th tare beat lands, the tare is formed
// by a reciprocal multiply in the next cycle, and the held beat waits until it is formed.
// Depends on lcst_pkg, lcst_input, lcst_tare and lcst_frame.
module load_cell_sum_tare_hex_frame (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [4*lcst_pkg::CODE_W-1:0] s_tdata,   // code_a, code_b, code_c, code_d
	input  logic                          s_tuser,   // retare
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // out_char
	output logic                          m_tlast    // frame_last
);
	import lcst_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  take;
	logic  frame_free;
	logic  wgt_load;
	wgt_t  wgt;

	lcst_input u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid    (valid_s1),
		.item     (item_s1)
	);

	lcst_tare u_tare (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (valid_s1),
		.item       (item_s1),
		.frame_free (frame_free),
		.take       (take),
		.wgt_load   (wgt_load),
		.wgt        (wgt)
	);

	lcst_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.wgt_load   (wgt_load),
		.wgt        (wgt),
		.frame_free (frame_free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== sim/tb.sv =====
// Testbench for load_cell_sum_tare_hex_frame: tare averaging, signed weight frames, stalls.
// Self-checking against an in-bench frame predictor; depends on lcst_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
	import lcst_pkg::CODE_W;
	import lcst_pkg::SAMPLE_BITS;
	import lcst_pkg::TARE_SAMPLES;
	import lcst_pkg::FRAME_LEN;

	localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
	localparam int DRAIN_CYCLES = 40;   // settle time after the last frame
	localparam int MAX_PRINTED = 40;

	localparam logic [7:0] CHR_0 = 8'h30;
	localparam logic [7:0] CHR_1 = 8'h31;
	localparam logic [7:0] CHR_X = 8'h78;
	localparam logic [7:0] CHR_A = 8'h41;

	localparam logic [SAMPLE_BITS-1:0] SIGN_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [CODE_W-1:0] EDGE_CODES [4] = '{24'h000000, 24'h7FFFFF, 24'h800000,
		24'hFFFFFF};

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} frame_char_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [4*CODE_W-1:0]   s_tdata = '0;   // code_a, code_b, code_c, code_d
	logic                  s_tuser = 1'b0; // retare
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // out_char
	logic                  m_tlast;        // frame_last

	frame_char_t pending_chars[$];

	// predictor state
	int           tare_cnt = 0;
	logic [63:0]  tare_tot = '0;
	logic [63:0]  tare_val = '0;
	logic [CODE_W-1:0] base_code [4] = '{default: '0};

	int mismatches = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_req_len = 0;
	int hold_req_seq = 0;
	int hold_seen_seq = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	load_cell_sum_tare_hex_frame i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		return (nib < 4'd10) ? CHR_0 + 8'(nib) : CHR_A + 8'(nib) - 8'd10;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("%0t ns mismatch: %s", $time, what);
		end
	endtask

	// Updates tare state for one accepted beat and queues the frame it produces, if any.
	task automatic predict_frame(input logic [4*CODE_W-1:0] data, input logic rt);
		logic [SAMPLE_BITS+1:0] sum;
		logic [63:0] diff;
		logic [31:0] mag;
		logic [7:0]  chk;
		logic        neg;
		logic [7:0]  chars [FRAME_LEN];
		sum = '0;
		if (rt) begin
			tare_cnt = 0;
			tare_tot = '0;
		end
		for (int k = 0; k < 4; k++) begin
			sum = sum + {2'b00, data[k*CODE_W +: SAMPLE_BITS] ^ SIGN_BIT};
		end
		if (tare_cnt < TARE_SAMPLES) begin
			tare_tot = tare_tot + sum;
			tare_cnt++;
			if (tare_cnt == TARE_SAMPLES) begin
				tare_val = tare_tot / TARE_SAMPLES;
			end
			return;
		end
		neg  = sum < tare_val;
		diff = neg ? tare_val - sum : sum - tare_val;
		mag  = diff[31:0];
		chk  = mag[7:0] ^ mag[15:8] ^ mag[23:16] ^ mag[31:24];
		chars[0] = neg ? CHR_1 : CHR_0;
		chars[1] = CHR_0;
		chars[2] = CHR_X;
		for (int i = 0; i < 8; i++) begin
			chars[3+i] = hex_ascii(mag[31-4*i -: 4]);
		end
		chars[11] = hex_ascii(chk[7:4]);
		chars[12] = hex_ascii(chk[3:0]);
		for (int i = 0; i < FRAME_LEN; i++) begin
			pending_chars.push_back('{ch: chars[i], last: (i == FRAME_LEN - 1)});
		end
	endtask

	// Offers one beat; valid stays high after the handshake until the next call or release.
	task automatic send_beat(input logic [4*CODE_W-1:0] data, input logic rt);
		int gap;
		@(negedge clk);
		if ($urandom_range(99) < src_idle_pct) begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= data;
		s_tuser  <= rt;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_frame(data, rt);
	endtask

	task automatic release_bus;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_frames_done;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	// Retare inside the tare phase, then all-edge codes against a known tare.
	task automatic test_tare_and_extremes;
		logic [4*CODE_W-1:0] data;
		for (int i = 0; i < 4; i++) begin
			data = {CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom)};
			send_beat(data, 1'b0);
		end
		// restart: this beat plus 14 more set tare to four mid-scale codes
		send_beat('0, 1'b1);
		for (int i = 0; i < TARE_SAMPLES - 1; i++) begin
			send_beat('0, 1'b0);
		end
		// zero weight, full positive, most negative, small negative
		for (int e = 0; e < 4; e++) begin
			send_beat({4{EDGE_CODES[e]}}, 1'b0);
		end
		send_beat({EDGE_CODES[0], EDGE_CODES[1], EDGE_CODES[2], EDGE_CODES[3]}, 1'b0);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [4*CODE_W-1:0] data;
		logic rt;
		int pick;
		for (int i = 0; i < n_items; i++) begin
			rt = ($urandom_range(199) < 3);
			if (rt) begin
				for (int k = 0; k < 4; k++) base_code[k] = CODE_W'($urandom);
			end
			pick = $urandom_range(99);
			for (int k = 0; k < 4; k++) begin
				// near the tare point gives small weights of both signs
				if (rt || tare_cnt < TARE_SAMPLES || pick < 50) begin
					data[k*CODE_W +: CODE_W] = base_code[k] + CODE_W'($urandom_range(256))
						- CODE_W'(128);
				end else if (pick < 85) begin
					data[k*CODE_W +: CODE_W] = CODE_W'($urandom);
				end else begin
					data[k*CODE_W +: CODE_W] = EDGE_CODES[$urandom_range(3)];
				end
			end
			send_beat(data, rt);
		end
	endtask

	// Long output stall while beats keep coming, so the input side backs up.
	task automatic test_output_backpressure;
		hold_req_len = 400;
		hold_req_seq++;
		test_random_traffic(25);
	endtask

	task automatic test_drain_pause;
		test_random_traffic(10);
		release_bus;
		wait_frames_done;
		test_random_traffic(10);
	endtask

	// Receiver: random ready, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_req_seq != hold_seen_seq) begin
			hold_seen_seq = hold_req_seq;
			hold_left = hold_req_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		frame_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("char 0x%02h last %0b with nothing pending",
					m_tdata, m_tlast));
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.ch) begin
					report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", m_tdata, want.ch));
				end
				if (m_tlast !== want.last) begin
					report_mismatch($sformatf("frame_last %0b, want %0b", m_tlast, want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		src_idle_pct = 38;
		snk_idle_pct = 88;
		test_tare_and_extremes;
		test_random_traffic(100);
		src_idle_pct = 88;
		snk_idle_pct = 38;
		test_random_traffic(100);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_traffic(100);
		test_output_backpressure;
		test_drain_pause;
		release_bus;
		wait_frames_done;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_chars.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lcst_pkg.sv
hw/rtl/lcst_input.sv
hw/rtl/lcst_tare.sv
hw/rtl/lcst_frame.sv
hw/rtl/load_cell_sum_tare_hex_frame.sv
sim/tb.sv
